@@ hw/rtl/bhs_pkg.sv @@
// Package for the bilinear height sampler: configuration and queue status types,
// register indices, mode codes and fixed datapath widths.
// Depends on nothing; the queue, front, back and top files refer to it by scoped names.
`default_nettype none

package bhs_pkg;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_HEIGHT      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CELLS_PER_UNIT_X = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CELLS_PER_UNIT_Z = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_GAIN      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS        = 3'd7;

	localparam logic [31:0] CELLS_PER_UNIT_RESET = 32'd65536;
	localparam logic [31:0] HEIGHT_GAIN_RESET    = 32'd257;
	localparam logic [8:0]  GRID_SIZE_RESET      = 9'd256;

	localparam int QUEUE_DEPTH = 4;

	// Blended height in Q16, its product with the gain, and the result before saturation.
	localparam int B16_W      = 30;
	localparam int PROD_W     = B16_W + 33;
	localparam int GAIN_SHIFT = 16;
	localparam int RES_W      = PROD_W - GAIN_SHIFT + 1;

	typedef struct packed {
		logic [31:0] origin_x;
		logic [31:0] origin_z;
		logic [31:0] base_height;
		logic [31:0] cells_per_unit_x;
		logic [31:0] cells_per_unit_z;
		logic [31:0] height_gain;
		logic [8:0]  grid_columns;
		logic [8:0]  grid_rows;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Width of one queue entry; must match the entry layout in the front and back parts.
	function automatic int entry_bits(input int addr_w, input int weight_w);
		return 16 + 5 * addr_w + 4 * weight_w;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bhs_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for each of the four banks of the height store; depends on nothing.
`default_nettype none

module bhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/bhs_queue.sv @@
// Short FIFO of request entries between the front and back parts of the sampler.
// Depends on bhs_pkg for the status type.
`default_nettype none

module bhs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [WIDTH-1:0]      push_data,
	input  wire logic                  pop,
	output logic      [WIDTH-1:0]      pop_data,
	output bhs_pkg::queue_status_t     status
);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_data     = entries_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !status.full)
		else $error("request pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !status.empty)
		else $error("request popped from an empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/bhs_front.sv @@
// Front part of the sampler: accepts requests, maps query positions to grid
// coordinates, clamps the corners and forms bank addresses and weights.
// Depends on bhs_pkg; feeds bhs_queue.
`default_nettype none

module bhs_front #(
	parameter int GRID_SIDE = 256,
	parameter int FRACTION_BITS = 16,
	localparam int IDX_W = (GRID_SIDE > 4) ? $clog2(GRID_SIDE) : 2,
	localparam int HALF_W = IDX_W - 1,
	localparam int AW = 2 * HALF_W,
	localparam int WW = FRACTION_BITS + 2,
	localparam int SIZE_W = ($clog2(GRID_SIDE + 1) > 9) ? $clog2(GRID_SIDE + 1) : 9,
	localparam int ENTRY_W = bhs_pkg::entry_bits(AW, WW)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  bhs_pkg::cfg_t              cfg,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  mode,
	input  wire logic [7:0]            write_column,
	input  wire logic [7:0]            write_row,
	input  wire logic [7:0]            sample_value,
	input  wire logic signed [31:0]    query_x,
	input  wire logic signed [31:0]    query_z,
	input  bhs_pkg::queue_status_t     q_status,
	output logic                       push,
	output logic      [ENTRY_W-1:0]    push_data
);

	typedef struct packed {
		logic                       is_query;
		logic                       wr_ok;
		logic [1:0]                 wr_bank;
		logic [AW-1:0]              wr_addr;
		logic [7:0]                 wr_data;
		logic [3:0][AW-1:0]         rd_addr;
		logic                       px0;
		logic                       px1;
		logic                       pz0;
		logic                       pz1;
		logic signed [WW-1:0]       wx0;
		logic signed [WW-1:0]       wx1;
		logic signed [WW-1:0]       wz0;
		logic signed [WW-1:0]       wz1;
	} entry_t;

	localparam logic [WW-1:0] ONE = WW'(1 << FRACTION_BITS);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	logic       mode_s1, mode_s2, mode_s3, mode_s4;
	logic [7:0] col_s1, col_s2, col_s3, col_s4;
	logic [7:0] row_s1, row_s2, row_s3, row_s4;
	logic [7:0] val_s1, val_s2, val_s3, val_s4;

	logic [32:0] dx_s1, dz_s1;
	logic        neg_x_s2, neg_z_s2, neg_x_s3, neg_z_s3, neg_x_s4, neg_z_s4;
	logic [32:0] mag_x_s2, mag_z_s2;
	logic [47:0] plx_s3, plz_s3;
	logic [48:0] phx_s3, phz_s3;
	logic [64:0] px_sum, pz_sum;
	logic [32:0] ip_x_s4, ip_z_s4;
	logic [FRACTION_BITS-1:0] fm_x_s4, fm_z_s4;

	logic [IDX_W-1:0] last_x, last_z;
	logic [IDX_W-1:0] x0, x1, z0, z1;
	logic [WW-1:0]    fxe, fze, wx1, wz1;
	logic [SIZE_W-1:0] colx, rowx;
	logic [IDX_W-1:0] cidx, ridx;
	entry_t entry;

	function automatic logic [IDX_W-1:0] last_index(input logic [8:0] size);
		logic [SIZE_W-1:0] n;
		n = (SIZE_W'(size) > SIZE_W'(GRID_SIDE)) ? SIZE_W'(GRID_SIDE) : SIZE_W'(size);
		return (n == '0) ? '0 : IDX_W'(n - SIZE_W'(1));
	endfunction

	function automatic logic [2*IDX_W-1:0] corner_pair(input logic neg, input logic [32:0] ip,
			input logic [IDX_W-1:0] last);
		logic [IDX_W-1:0] i0;
		logic [IDX_W-1:0] i1;
		if (neg) begin
			i0 = '0;
			i1 = (ip == 33'd0 && last != '0) ? IDX_W'(1) : '0;
		end else if (ip >= 33'(last)) begin
			i0 = last;
			i1 = last;
		end else begin
			i0 = ip[IDX_W-1:0];
			i1 = ip[IDX_W-1:0] + IDX_W'(1);
		end
		return {i1, i0};
	endfunction

	assign adv      = !v_s4 || !q_status.full;
	assign in_ready = adv;
	assign push     = v_s4 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		px_sum = {phx_s3, 16'b0} + 65'(plx_s3);
		pz_sum = {phz_s3, 16'b0} + 65'(plz_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			col_s1  <= write_column;
			row_s1  <= write_row;
			val_s1  <= sample_value;
			dx_s1   <= {query_x[31], query_x} - {cfg.origin_x[31], cfg.origin_x};
			dz_s1   <= {query_z[31], query_z} - {cfg.origin_z[31], cfg.origin_z};

			mode_s2  <= mode_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			val_s2   <= val_s1;
			neg_x_s2 <= dx_s1[32];
			neg_z_s2 <= dz_s1[32];
			mag_x_s2 <= dx_s1[32] ? (~dx_s1 + 33'd1) : dx_s1;
			mag_z_s2 <= dz_s1[32] ? (~dz_s1 + 33'd1) : dz_s1;

			mode_s3  <= mode_s2;
			col_s3   <= col_s2;
			row_s3   <= row_s2;
			val_s3   <= val_s2;
			neg_x_s3 <= neg_x_s2;
			neg_z_s3 <= neg_z_s2;
			plx_s3   <= 48'(mag_x_s2[15:0]) * 48'(cfg.cells_per_unit_x);
			phx_s3   <= 49'(mag_x_s2[32:16]) * 49'(cfg.cells_per_unit_x);
			plz_s3   <= 48'(mag_z_s2[15:0]) * 48'(cfg.cells_per_unit_z);
			phz_s3   <= 49'(mag_z_s2[32:16]) * 49'(cfg.cells_per_unit_z);

			mode_s4  <= mode_s3;
			col_s4   <= col_s3;
			row_s4   <= row_s3;
			val_s4   <= val_s3;
			neg_x_s4 <= neg_x_s3;
			neg_z_s4 <= neg_z_s3;
			ip_x_s4  <= px_sum[64:32];
			ip_z_s4  <= pz_sum[64:32];
			fm_x_s4  <= px_sum[31:32-FRACTION_BITS];
			fm_z_s4  <= pz_sum[31:32-FRACTION_BITS];
		end
	end

	always_comb begin
		last_x     = last_index(cfg.grid_columns);
		last_z     = last_index(cfg.grid_rows);
		{x1, x0}   = corner_pair(neg_x_s4, ip_x_s4, last_x);
		{z1, z0}   = corner_pair(neg_z_s4, ip_z_s4, last_z);

		fxe = WW'(fm_x_s4);
		fze = WW'(fm_z_s4);
		wx1 = neg_x_s4 ? (~fxe + WW'(1)) : fxe;
		wz1 = neg_z_s4 ? (~fze + WW'(1)) : fze;

		colx = SIZE_W'(col_s4);
		rowx = SIZE_W'(row_s4);
		cidx = colx[IDX_W-1:0];
		ridx = rowx[IDX_W-1:0];

		entry.is_query = (mode_s4 == bhs_pkg::MODE_QUERY);
		entry.wr_ok    = (colx < SIZE_W'(GRID_SIDE)) && (rowx < SIZE_W'(GRID_SIDE));
		entry.wr_bank  = {ridx[0], cidx[0]};
		entry.wr_addr  = {ridx[IDX_W-1:1], cidx[IDX_W-1:1]};
		entry.wr_data  = val_s4;
		for (int b = 0; b < 4; b++) begin
			entry.rd_addr[b] = {((z0[0] == 1'(b >> 1)) ? z0[IDX_W-1:1] : z1[IDX_W-1:1]),
				((x0[0] == 1'(b)) ? x0[IDX_W-1:1] : x1[IDX_W-1:1])};
		end
		entry.px0 = x0[0];
		entry.px1 = x1[0];
		entry.pz0 = z0[0];
		entry.pz1 = z1[0];
		entry.wx0 = ONE - wx1;
		entry.wx1 = wx1;
		entry.wz0 = ONE - wz1;
		entry.wz1 = wz1;
	end

	assign push_data = entry;

endmodule

`default_nettype wire

@@ hw/rtl/bhs_back.sv @@
// Back part of the sampler: performs grid writes, reads the four corner banks,
// blends, applies gain and base height, saturates and holds the result.
// Depends on bhs_pkg and bhs_ram; fed by bhs_queue.
`default_nettype none

module bhs_back #(
	parameter int GRID_SIDE = 256,
	parameter int FRACTION_BITS = 16,
	localparam int IDX_W = (GRID_SIDE > 4) ? $clog2(GRID_SIDE) : 2,
	localparam int HALF_W = IDX_W - 1,
	localparam int AW = 2 * HALF_W,
	localparam int WW = FRACTION_BITS + 2,
	localparam int ENTRY_W = bhs_pkg::entry_bits(AW, WW)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  bhs_pkg::cfg_t              cfg,
	input  bhs_pkg::queue_status_t     q_status,
	output logic                       pop,
	input  wire logic [ENTRY_W-1:0]    pop_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [31:0]         surface_height,
	output logic                       saturated
);

	typedef struct packed {
		logic                       is_query;
		logic                       wr_ok;
		logic [1:0]                 wr_bank;
		logic [AW-1:0]              wr_addr;
		logic [7:0]                 wr_data;
		logic [3:0][AW-1:0]         rd_addr;
		logic                       px0;
		logic                       px1;
		logic                       pz0;
		logic                       pz1;
		logic signed [WW-1:0]       wx0;
		logic signed [WW-1:0]       wx1;
		logic signed [WW-1:0]       wz0;
		logic signed [WW-1:0]       wz1;
	} entry_t;

	localparam int RW = WW + 10;
	localparam int SW = RW + WW + 1;
	localparam int SHIFT = 2 * FRACTION_BITS - 16;
	localparam int BANK_DEPTH = 1 << AW;
	localparam int RES_W = bhs_pkg::RES_W;
	localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(signed'(32'h7fff_ffff));
	localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(signed'(32'h8000_0000));

	entry_t entry;
	logic adv;
	logic [3:0] ram_wr_en;
	logic       ram_rd_en;
	logic [7:0] bank_data [4];

	logic v_s1, v_s2, v_s3, v_s4;
	logic px0_s1, px1_s1, pz0_s1, pz1_s1;
	logic signed [WW-1:0] wx0_s1, wx1_s1, wz0_s1, wz1_s1, wz0_s2, wz1_s2;
	logic [7:0] c00, c10, c01, c11;
	logic signed [RW-1:0] r0, r1, r0_s2, r1_s2;
	logic signed [SW-1:0] sum, sum_sh;
	logic signed [bhs_pkg::B16_W-1:0] b16_s3;
	logic signed [bhs_pkg::PROD_W-1:0] prod_s4;
	logic signed [RES_W-1:0] res;

	logic               out_valid_q;
	logic signed [31:0] surface_height_q;
	logic               saturated_q;

	assign entry     = pop_data;
	assign adv       = !out_valid_q || out_ready;
	assign pop       = adv && !q_status.empty;
	assign ram_rd_en = pop && entry.is_query;

	for (genvar gb = 0; gb < 4; gb++) begin : g_bank
		assign ram_wr_en[gb] = pop && !entry.is_query && entry.wr_ok && (entry.wr_bank == 2'(gb));

		bhs_ram #(
			.WIDTH (8),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (ram_wr_en[gb]),
			.wr_addr (entry.wr_addr),
			.wr_data (entry.wr_data),
			.rd_en   (ram_rd_en),
			.rd_addr (entry.rd_addr[gb]),
			.rd_data (bank_data[gb])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= ram_rd_en;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_comb begin
		c00 = bank_data[{pz0_s1, px0_s1}];
		c10 = bank_data[{pz0_s1, px1_s1}];
		c01 = bank_data[{pz1_s1, px0_s1}];
		c11 = bank_data[{pz1_s1, px1_s1}];
		r0 = RW'($signed({1'b0, c00})) * RW'(wx0_s1) + RW'($signed({1'b0, c10})) * RW'(wx1_s1);
		r1 = RW'($signed({1'b0, c01})) * RW'(wx0_s1) + RW'($signed({1'b0, c11})) * RW'(wx1_s1);
		sum    = SW'(r0_s2) * SW'(wz0_s2) + SW'(r1_s2) * SW'(wz1_s2);
		sum_sh = sum >>> SHIFT;
		res    = RES_W'(prod_s4 >>> bhs_pkg::GAIN_SHIFT) + RES_W'($signed(cfg.base_height));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px0_s1 <= entry.px0;
			px1_s1 <= entry.px1;
			pz0_s1 <= entry.pz0;
			pz1_s1 <= entry.pz1;
			wx0_s1 <= entry.wx0;
			wx1_s1 <= entry.wx1;
			wz0_s1 <= entry.wz0;
			wz1_s1 <= entry.wz1;

			r0_s2  <= r0;
			r1_s2  <= r1;
			wz0_s2 <= wz0_s1;
			wz1_s2 <= wz1_s1;

			b16_s3 <= sum_sh[bhs_pkg::B16_W-1:0];

			prod_s4 <= bhs_pkg::PROD_W'(b16_s3) *
				bhs_pkg::PROD_W'($signed({1'b0, cfg.height_gain}));

			if (res > SAT_MAX) begin
				surface_height_q <= 32'sh7fff_ffff;
				saturated_q      <= 1'b1;
			end else if (res < SAT_MIN) begin
				surface_height_q <= 32'sh8000_0000;
				saturated_q      <= 1'b1;
			end else begin
				surface_height_q <= res[31:0];
				saturated_q      <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign surface_height = surface_height_q;
	assign saturated      = saturated_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(surface_height == 32'sh7fff_ffff || surface_height == 32'sh8000_0000))
		else $error("saturated result is not at either end of the range");
	assert property (@(posedge clk) disable iff (!arst_n) (|ram_wr_en) |-> !ram_rd_en)
		else $error("grid write and corner read issued in the same cycle");

endmodule

`default_nettype wire

@@ hw/rtl/bilinear_height_sampler_unit.sv @@
// Top level of the bilinear height sampler: configuration registers, front part,
// request queue and back part. Depends on bhs_pkg, bhs_front, bhs_queue and bhs_back.
//
//  Channel   Handshake              Carries
//  in        in_valid / in_ready    mode, write_column, write_row, sample_value, query_x, query_z
//  out       out_valid / out_ready  surface_height, saturated (one per query request)
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// One request is accepted per cycle when nothing stalls; a query's result passes through
// four front stages, the queue, the registered bank read, three arithmetic stages and the
// output register. Write requests give no result.
// Reset restores the configuration defaults and empties every stage and the queue;
// the height store is not cleared and must be loaded before it is read.
// An output stall freezes only the back part; the front keeps accepting until the
// four-entry queue is full.
`default_nettype none

module bilinear_height_sampler_unit #(
	parameter int GRID_SIDE = 256,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            mode,
	input  wire logic [7:0]                      write_column,
	input  wire logic [7:0]                      write_row,
	input  wire logic [7:0]                      sample_value,
	input  wire logic signed [31:0]              query_x,
	input  wire logic signed [31:0]              query_z,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [31:0]                   surface_height,
	output logic                                 saturated,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bhs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	localparam int IDX_W = (GRID_SIDE > 4) ? $clog2(GRID_SIDE) : 2;
	localparam int AW = 2 * (IDX_W - 1);
	localparam int WW = FRACTION_BITS + 2;
	localparam int ENTRY_W = bhs_pkg::entry_bits(AW, WW);

	bhs_pkg::cfg_t          cfg_q;
	bhs_pkg::queue_status_t q_status;
	logic                   push;
	logic                   pop;
	logic [ENTRY_W-1:0]     push_data;
	logic [ENTRY_W-1:0]     pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x         <= '0;
			cfg_q.origin_z         <= '0;
			cfg_q.base_height      <= '0;
			cfg_q.cells_per_unit_x <= bhs_pkg::CELLS_PER_UNIT_RESET;
			cfg_q.cells_per_unit_z <= bhs_pkg::CELLS_PER_UNIT_RESET;
			cfg_q.height_gain      <= bhs_pkg::HEIGHT_GAIN_RESET;
			cfg_q.grid_columns     <= bhs_pkg::GRID_SIZE_RESET;
			cfg_q.grid_rows        <= bhs_pkg::GRID_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bhs_pkg::REG_ORIGIN_X:         cfg_q.origin_x         <= cfg_data;
				bhs_pkg::REG_ORIGIN_Z:         cfg_q.origin_z         <= cfg_data;
				bhs_pkg::REG_BASE_HEIGHT:      cfg_q.base_height      <= cfg_data;
				bhs_pkg::REG_CELLS_PER_UNIT_X: cfg_q.cells_per_unit_x <= cfg_data;
				bhs_pkg::REG_CELLS_PER_UNIT_Z: cfg_q.cells_per_unit_z <= cfg_data;
				bhs_pkg::REG_HEIGHT_GAIN:      cfg_q.height_gain      <= cfg_data;
				bhs_pkg::REG_GRID_COLUMNS:     cfg_q.grid_columns     <= cfg_data[8:0];
				bhs_pkg::REG_GRID_ROWS:        cfg_q.grid_rows        <= cfg_data[8:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bhs_front #(
		.GRID_SIDE     (GRID_SIDE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.write_column (write_column),
		.write_row    (write_row),
		.sample_value (sample_value),
		.query_x      (query_x),
		.query_z      (query_z),
		.q_status     (q_status),
		.push         (push),
		.push_data    (push_data)
	);

	bhs_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (bhs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	bhs_back #(
		.GRID_SIDE     (GRID_SIDE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_status       (q_status),
		.pop            (pop),
		.pop_data       (pop_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.surface_height (surface_height),
		.saturated      (saturated)
	);

endmodule

`default_nettype wire

@@ sim/bilinear_height_sampler_unit_test.sv @@
// Self-checking testbench for bilinear_height_sampler_unit.
// It predicts every query result from its own copy of the registers and the height grid.
// Depends on bhs_pkg and the RTL of the block only.
`default_nettype none

module bilinear_height_sampler_unit_test;
	import bhs_pkg::*;

	localparam int STORE_SIDE = 256;
	localparam int FRAC = 16;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	localparam int SETTLE_CYCLES = 16;
	localparam int TARGET_REQUESTS = 950;

	typedef struct packed {
		logic signed [31:0] surface_height;
		logic               saturated;
	} height_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   mode;
	logic [7:0]             write_column;
	logic [7:0]             write_row;
	logic [7:0]             sample_value;
	logic signed [31:0]     query_x;
	logic signed [31:0]     query_z;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [31:0]     surface_height;
	logic                   saturated;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;

	logic [7:0]     height_codes [STORE_SIDE*STORE_SIDE];
	bit             code_loaded [STORE_SIDE*STORE_SIDE];
	cfg_t           cfg;
	height_result_t pending_heights [$];
	height_result_t due;
	int             failures, total_requests, write_count, query_count;
	int             saturated_count, settings_applied;
	bit             calm_sender, calm_receiver, slow_receiver;

	bilinear_height_sampler_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.write_column(write_column),
		.write_row(write_row),
		.sample_value(sample_value),
		.query_x(query_x),
		.query_z(query_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.surface_height(surface_height),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("bilinear_height_sampler_unit: mismatch");
		$finish;
	end

	function automatic longint top_index(input logic [8:0] size);
		if (size > 9'd256)
			return STORE_SIDE - 1;
		if (size == 9'd0)
			return 0;
		return longint'(size) - 1;
	endfunction

	function automatic longint clamp_to(input longint i, input longint lim);
		if (i < 0)
			return 0;
		return (i > lim) ? lim : i;
	endfunction

	// Grid coordinate: integer part truncated toward zero, fraction carrying the sign.
	function automatic void map_axis(input logic signed [31:0] pos, input logic signed [31:0] org,
			input logic [31:0] rate, output longint ipart, output longint frac);
		longint     d;
		logic [63:0] mag, p;
		d = longint'(pos) - longint'(org);
		mag = (d < 0) ? -d : d;
		p = mag * {32'd0, rate};
		ipart = longint'(p[63:32]);
		frac = longint'(p[31:32-FRAC]);
		if (d < 0) begin
			ipart = -ipart;
			frac = -frac;
		end
	endfunction

	function automatic void locate(input logic [31:0] qx, input logic [31:0] qz,
			output longint x0, output longint x1, output longint z0, output longint z1,
			output longint fx, output longint fz);
		longint ix, iz, lx, lz;
		map_axis(qx, cfg.origin_x, cfg.cells_per_unit_x, ix, fx);
		map_axis(qz, cfg.origin_z, cfg.cells_per_unit_z, iz, fz);
		lx = top_index(cfg.grid_columns);
		lz = top_index(cfg.grid_rows);
		x0 = clamp_to(ix, lx);
		x1 = clamp_to(ix + 1, lx);
		z0 = clamp_to(iz, lz);
		z1 = clamp_to(iz + 1, lz);
	endfunction

	function automatic longint code_at(input longint col, input longint row);
		return longint'(height_codes[int'(row * STORE_SIDE + col)]);
	endfunction

	function automatic height_result_t predict_surface(input logic [31:0] qx, input logic [31:0] qz);
		longint         x0, x1, z0, z1, fx, fz, sum, b16, total;
		height_result_t r;
		locate(qx, qz, x0, x1, z0, z1, fx, fz);
		sum = code_at(x0, z0) * (ONE - fx) * (ONE - fz) + code_at(x1, z0) * fx * (ONE - fz) +
			code_at(x0, z1) * (ONE - fx) * fz + code_at(x1, z1) * fx * fz;
		b16 = sum >>> (2 * FRAC - 16);
		total = ((b16 * longint'({32'd0, cfg.height_gain})) >>> 16) +
			longint'(signed'(cfg.base_height));
		r.saturated = 1'b1;
		if (total > WORD_MAX)
			total = WORD_MAX;
		else if (total < WORD_MIN)
			total = WORD_MIN;
		else
			r.saturated = 1'b0;
		r.surface_height = total[31:0];
		return r;
	endfunction

	function automatic int sender_gap();
		int r;
		if (calm_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom;
			default: return $urandom_range(0, 600 * 65536) - 300 * 65536;
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return $urandom;
			3, 4, 5: return 32'h0001_0000;
			default: return $urandom_range(8192, 262144);
		endcase
	endfunction

	function automatic logic [8:0] pick_size();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 2))
					0: return 9'd0;
					1: return 9'd1;
					default: return $urandom_range(257, 511);
				endcase
			end
			1: return 9'd256;
			2: return $urandom_range(2, 256);
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	// A world position that lands near or inside the grid in use, now and then anywhere.
	function automatic logic [31:0] aim_axis(input logic [31:0] org, input logic [31:0] rate,
			input logic [8:0] size);
		longint      tgt, pos;
		int unsigned lim;
		if (rate == 32'd0 || $urandom_range(0, 9) == 0)
			return $urandom;
		lim = (top_index(size) + 3) * ONE;
		tgt = longint'($urandom_range(0, lim)) - 2 * ONE;
		if ($urandom_range(0, 3) == 0)
			tgt = tgt - (tgt % ONE);
		pos = longint'(signed'(org)) + tgt * ONE / longint'({32'd0, rate});
		if (pos > WORD_MAX)
			pos = WORD_MAX;
		else if (pos < WORD_MIN)
			pos = WORD_MIN;
		return pos[31:0];
	endfunction

	task automatic send_request(input logic m, input logic [7:0] col, input logic [7:0] row,
			input logic [7:0] code, input logic [31:0] qx, input logic [31:0] qz);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		write_column <= col;
		write_row <= row;
		sample_value <= code;
		query_x <= qx;
		query_z <= qz;
		do @(posedge clk); while (!in_ready);
		total_requests++;
		if (m == MODE_WRITE) begin
			height_codes[int'(row) * STORE_SIDE + int'(col)] = code;
			code_loaded[int'(row) * STORE_SIDE + int'(col)] = 1'b1;
			write_count++;
		end else begin
			pending_heights.push_back(predict_surface(qx, qz));
			query_count++;
		end
	endtask

	// Any corner that the query will read and that holds no code yet is written first.
	task automatic send_query(input logic [31:0] qx, input logic [31:0] qz);
		longint x0, x1, z0, z1, fx, fz, col, row;
		locate(qx, qz, x0, x1, z0, z1, fx, fz);
		for (int k = 0; k < 4; k++) begin
			col = k[0] ? x1 : x0;
			row = k[1] ? z1 : z0;
			if (!code_loaded[int'(row * STORE_SIDE + col)])
				send_request(MODE_WRITE, col[7:0], row[7:0], $urandom, $urandom, $urandom);
		end
		send_request(MODE_QUERY, $urandom, $urandom, $urandom, qx, qz);
	endtask

	task automatic idle_until_drained();
		in_valid <= 1'b0;
		while (pending_heights.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ORIGIN_X:         cfg.origin_x = data;
			REG_ORIGIN_Z:         cfg.origin_z = data;
			REG_BASE_HEIGHT:      cfg.base_height = data;
			REG_CELLS_PER_UNIT_X: cfg.cells_per_unit_x = data;
			REG_CELLS_PER_UNIT_Z: cfg.cells_per_unit_z = data;
			REG_HEIGHT_GAIN:      cfg.height_gain = data;
			REG_GRID_COLUMNS:     cfg.grid_columns = data[8:0];
			REG_GRID_ROWS:        cfg.grid_rows = data[8:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input cfg_t want);
		logic [31:0] junk;
		write_register(REG_ORIGIN_X, want.origin_x);
		write_register(REG_ORIGIN_Z, want.origin_z);
		write_register(REG_BASE_HEIGHT, want.base_height);
		write_register(REG_CELLS_PER_UNIT_X, want.cells_per_unit_x);
		write_register(REG_CELLS_PER_UNIT_Z, want.cells_per_unit_z);
		write_register(REG_HEIGHT_GAIN, want.height_gain);
		junk = $urandom;
		write_register(REG_GRID_COLUMNS, {junk[31:9], want.grid_columns});
		junk = $urandom;
		write_register(REG_GRID_ROWS, {junk[31:9], want.grid_rows});
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic test_reset_defaults();
		send_request(MODE_WRITE, 8'd0, 8'd0, 8'h00, $urandom, $urandom);
		send_request(MODE_WRITE, 8'd1, 8'd0, 8'hff, $urandom, $urandom);
		send_request(MODE_WRITE, 8'd0, 8'd1, 8'hff, $urandom, $urandom);
		send_request(MODE_WRITE, 8'd255, 8'd255, 8'h80, $urandom, $urandom);
		send_query(32'h0000_0000, 32'h0000_0000);
		send_query(32'h0000_8000, 32'h0000_8000);
		send_query(32'h0000_ffff, 32'h0000_ffff);
		send_query(-32'sh0000_ffff, 32'h0001_8000);
		send_query(32'h00ff_0000, 32'h00ff_0000);
		send_query(32'h7fff_ffff, 32'h7fff_ffff);
		send_query(32'h8000_0000, 32'h8000_0000);
	endtask

	task automatic test_special_cases();
		cfg_t want;
		want = cfg;
		idle_until_drained();
		want.base_height = 32'h7fff_ffff;
		want.height_gain = 32'hffff_ffff;
		apply_settings(want);
		send_query(32'h0001_0000, 32'h0000_0000);
		send_query(32'h0000_0000, 32'h0000_0000);
		idle_until_drained();
		want.base_height = 32'h8000_0000;
		want.height_gain = 32'h0001_0000;
		apply_settings(want);
		send_query(-32'sh0000_ffff, 32'h0000_0000);
		send_query(32'h0001_0000, 32'h0000_0000);
		idle_until_drained();
		want = '{origin_x: 32'h7fff_ffff, origin_z: 32'h8000_0000, base_height: 32'h0,
			cells_per_unit_x: 32'hffff_ffff, cells_per_unit_z: 32'h0,
			height_gain: HEIGHT_GAIN_RESET, grid_columns: 9'd0, grid_rows: 9'd511};
		apply_settings(want);
		send_query(32'h8000_0000, 32'h7fff_ffff);
		send_query(32'h7fff_ffff, 32'h8000_0000);
		idle_until_drained();
		want = '{origin_x: 32'h0, origin_z: 32'h0, base_height: 32'h0,
			cells_per_unit_x: CELLS_PER_UNIT_RESET, cells_per_unit_z: CELLS_PER_UNIT_RESET,
			height_gain: 32'h0, grid_columns: 9'd1, grid_rows: 9'd257};
		apply_settings(want);
		send_query(32'h0005_0000, 32'h0100_0000);
	endtask

	task automatic test_burst_then_pause();
		cfg_t want;
		idle_until_drained();
		want = '{origin_x: 32'h0, origin_z: 32'h0, base_height: 32'h0,
			cells_per_unit_x: CELLS_PER_UNIT_RESET, cells_per_unit_z: CELLS_PER_UNIT_RESET,
			height_gain: HEIGHT_GAIN_RESET, grid_columns: 9'd4, grid_rows: 9'd4};
		apply_settings(want);
		calm_sender = 1'b1;
		slow_receiver = 1'b1;
		for (int k = 0; k < 16; k++)
			send_query(aim_axis(cfg.origin_x, cfg.cells_per_unit_x, cfg.grid_columns),
				aim_axis(cfg.origin_z, cfg.cells_per_unit_z, cfg.grid_rows));
		idle_until_drained();
		slow_receiver = 1'b0;
		calm_receiver = 1'b1;
		for (int k = 0; k < 16; k++)
			send_query(aim_axis(cfg.origin_x, cfg.cells_per_unit_x, cfg.grid_columns),
				aim_axis(cfg.origin_z, cfg.cells_per_unit_z, cfg.grid_rows));
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
	endtask

	task automatic test_random_traffic();
		cfg_t want;
		int   phase_len, cols_used, rows_used;
		while (total_requests < TARGET_REQUESTS) begin
			idle_until_drained();
			want.origin_x = pick_offset();
			want.origin_z = pick_offset();
			want.base_height = pick_offset();
			want.cells_per_unit_x = pick_scale();
			want.cells_per_unit_z = pick_scale();
			want.height_gain = pick_scale();
			want.grid_columns = pick_size();
			want.grid_rows = pick_size();
			apply_settings(want);
			calm_sender = ($urandom_range(0, 4) == 0);
			calm_receiver = ($urandom_range(0, 4) == 0);
			cols_used = top_index(cfg.grid_columns) + 1;
			rows_used = top_index(cfg.grid_rows) + 1;
			if (cols_used * rows_used <= 64 && $urandom_range(0, 1) == 1) begin
				for (int r = 0; r < rows_used; r++)
					for (int c = 0; c < cols_used; c++)
						send_request(MODE_WRITE, c, r, $urandom, $urandom, $urandom);
			end
			phase_len = $urandom_range(60, 140);
			for (int k = 0; k < phase_len && total_requests < TARGET_REQUESTS; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					if ($urandom_range(0, 9) < 7)
						send_request(MODE_WRITE, $urandom_range(0, cols_used - 1),
							$urandom_range(0, rows_used - 1), $urandom, $urandom, $urandom);
					else
						send_request(MODE_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
				end else begin
					send_query(aim_axis(cfg.origin_x, cfg.cells_per_unit_x, cfg.grid_columns),
						aim_axis(cfg.origin_z, cfg.cells_per_unit_z, cfg.grid_rows));
				end
			end
		end
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
	endtask

	initial begin
		int run, stall;
		forever begin
			if (calm_receiver) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
				if (slow_receiver)
					stall = $urandom_range(20, 60);
				else if ($urandom_range(0, 19) == 0)
					stall = $urandom_range(10, 40);
				else
					stall = $urandom_range(1, 3);
				out_ready <= 1'b1;
				repeat (run) @(posedge clk);
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_heights.size() == 0) begin
				$error("surface_height %0d arrived with no query outstanding", surface_height);
				failures++;
			end else begin
				due = pending_heights.pop_front();
				if (surface_height !== due.surface_height) begin
					$error("surface_height expected %0d, actual %0d", due.surface_height,
						surface_height);
					failures++;
				end
				if (saturated !== due.saturated) begin
					$error("saturated expected %0b, actual %0b", due.saturated, saturated);
					failures++;
				end
				if (due.saturated)
					saturated_count++;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_WRITE;
		write_column <= 8'd0;
		write_row <= 8'd0;
		sample_value <= 8'd0;
		query_x <= 32'sd0;
		query_z <= 32'sd0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ORIGIN_X;
		cfg_data <= 32'd0;
		cfg = '{origin_x: 32'h0, origin_z: 32'h0, base_height: 32'h0,
			cells_per_unit_x: CELLS_PER_UNIT_RESET, cells_per_unit_z: CELLS_PER_UNIT_RESET,
			height_gain: HEIGHT_GAIN_RESET, grid_columns: GRID_SIZE_RESET,
			grid_rows: GRID_SIZE_RESET};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_special_cases();
		test_burst_then_pause();
		test_random_traffic();
		idle_until_drained();
		$display("Run covered %0d height writes and %0d queries, %0d of them saturated,",
			write_count, query_count, saturated_count);
		$display("across %0d register settings with random and steady flow on both sides.",
			settings_applied);
		if (failures == 0 && pending_heights.size() == 0)
			$display("bilinear_height_sampler_unit: match");
		else
			$display("bilinear_height_sampler_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
